@@ design/isc_pkg.sv @@
`timescale 1ns / 1ps
package isc_pkg;

  // Operation codes on the input channel.
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  // Status codes on the result channel.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  // One stored interval: start and inclusive end, both two's complement.
  typedef struct packed {
    logic [31:0] ival_start;
    logic [33:0] ival_end;
  } cell_data_t;

  // Interval being added or queried, widened to 34 bits.
  typedef struct packed {
    logic [33:0] ival_start;
    logic [33:0] ival_end;
  } pend_t;

  // Position of a cell relative to the pending interval.
  typedef struct packed {
    logic below;
    logic ovl;
  } cell_flags_t;

  // Command broadcast to every cell.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_DEL,
    CMD_INS
  } cell_cmd_t;

endpackage

@@ design/isc_cell.sv @@
`timescale 1ns / 1ps
module isc_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  isc_pkg::cell_cmd_t  cmd,
  input  logic                valid,
  input  isc_pkg::pend_t      pend,
  input  isc_pkg::cell_data_t prev_data,
  input  isc_pkg::cell_data_t next_data,
  input  isc_pkg::cell_flags_t prev_flags,
  output isc_pkg::cell_data_t data,
  output isc_pkg::cell_flags_t flags
);

  isc_pkg::cell_data_t  data_r, data_nxt;
  isc_pkg::cell_flags_t flags_r, flags_nxt;
  logic [33:0]          own_start;

  assign own_start = {{2{data_r.ival_start[31]}}, data_r.ival_start};

  // Entries at or above the pending interval move one place; lower ones stay.
  always_comb begin
    data_nxt = data_r;
    case (cmd)
      isc_pkg::CMD_DEL: begin
        if (!flags_r.below) data_nxt = next_data;
      end
      isc_pkg::CMD_INS: begin
        if (!flags_r.below) begin
          if (prev_flags.below) begin
            data_nxt = {pend.ival_start[31:0], pend.ival_end};
          end else begin
            data_nxt = prev_data;
          end
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  // Compare against the pending interval; ends count as inclusive.
  always_comb begin
    flags_nxt.below = valid && ($signed(data_r.ival_end) < $signed(pend.ival_start));
    flags_nxt.ovl   = valid && !($signed(pend.ival_start) > $signed(data_r.ival_end))
                            && !($signed(pend.ival_end) < $signed(own_start));
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  assign data  = data_r;
  assign flags = flags_r;

endmodule

@@ design/interval_set_coalesce_overlap.sv @@
`timescale 1ns / 1ps
// Coalesced interval table built as a row of cells, one stored interval each.
// Input channel: an operation is transferred when start is high and busy is low.
// in_func selects clear, add, overlap query or read of the entry at in_entry_index.
// Result channel: out_valid strobes for one cycle with every result field; the
// receiver cannot stall, so each result is taken in the cycle it appears.
// Steps from the transfer to the strobe:
//   clear, read: the result is registered straight from the idle state.
//   query: every cell compares in the compare state; eval combines the flags.
//   add: compare and eval repeat for each stored entry the new interval absorbs;
//   each such eval merges the lowest overlapping entry while all higher cells
//   move down by one place, and a final eval inserts the interval if a cell is free.
// busy is high from transfer to strobe for query and add (clear and read keep
// it low); one operation is in flight at a time; the merge loop sets the rate.
// Reset clears the entry count, control and cell flags; cell contents are left as
// they are and are never read before being written.
// An add that absorbs nothing while all CAPACITY cells are used is dropped with
// status table full.
module interval_set_coalesce_overlap #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic signed [31:0] in_interval_start,
  input  logic [31:0] in_interval_length,
  input  logic [5:0]  in_entry_index,
  output logic        out_valid,
  output logic        out_overlap_found,
  output logic signed [31:0] out_entry_start,
  output logic [32:0] out_entry_length,
  output logic [6:0]  out_entry_count,
  output logic [1:0]  out_status
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > 6) ? CW : 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EVAL
  } state_t;

  state_t              state_r;
  logic [1:0]          func_r;
  logic [CW-1:0]       count_r;
  isc_pkg::pend_t      pend_r;
  isc_pkg::cell_cmd_t  cmd;

  isc_pkg::cell_data_t  cdata  [CAPACITY];
  isc_pkg::cell_flags_t cflags [CAPACITY];
  logic [CAPACITY-1:0]  ovl_vec;
  logic [CAPACITY-1:0]  first_ovl;
  logic                 any_ovl;
  isc_pkg::cell_data_t  mrg_data;
  isc_pkg::cell_data_t  rd_data;
  logic [33:0]          mrg_start;
  logic [33:0]          new_start;
  logic [33:0]          new_end;
  logic [33:0]          rd_len;
  logic [CW+6:0]        count_ext;
  logic                 accept;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  // Row of cells; each sees its neighbors' data and its lower neighbor's flags.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    isc_pkg::cell_data_t  prev_d, next_d;
    isc_pkg::cell_flags_t prev_f;
    logic                 cvalid;

    assign cvalid = (CW'(gi) < count_r);
    if (gi == 0) begin : g_first
      assign prev_d = {pend_r.ival_start[31:0], pend_r.ival_end};
      assign prev_f = '{below: 1'b1, ovl: 1'b0};
    end else begin : g_mid
      assign prev_d = cdata[gi-1];
      assign prev_f = cflags[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign next_d = {pend_r.ival_start[31:0], pend_r.ival_end};
    end else begin : g_inner
      assign next_d = cdata[gi+1];
    end

    isc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .valid      (cvalid),
      .pend       (pend_r),
      .prev_data  (prev_d),
      .next_data  (next_d),
      .prev_flags (prev_f),
      .data       (cdata[gi]),
      .flags      (cflags[gi])
    );

    assign ovl_vec[gi]   = cflags[gi].ovl;
    assign first_ovl[gi] = cflags[gi].ovl && !prev_f.ovl;
  end

  assign any_ovl = |ovl_vec;

  // Select the lowest overlapping entry and the entry addressed by a read.
  always_comb begin
    mrg_data = '0;
    rd_data  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_ovl[i]) mrg_data = mrg_data | cdata[i];
      if (IW'(i) == IW'(in_entry_index)) rd_data = rd_data | cdata[i];
    end
  end

  assign mrg_start = {{2{mrg_data.ival_start[31]}}, mrg_data.ival_start};
  assign new_start = {{2{in_interval_start[31]}}, in_interval_start};
  assign new_end   = new_start + {2'b00, in_interval_length};
  assign rd_len    = rd_data.ival_end - {{2{rd_data.ival_start[31]}}, rd_data.ival_start};

  // Shift command for the cells during an add.
  always_comb begin
    cmd = isc_pkg::CMD_HOLD;
    if (state_r == ST_EVAL && func_r == isc_pkg::FUNC_ADD) begin
      if (any_ovl) begin
        cmd = isc_pkg::CMD_DEL;
      end else if (count_r != CW'(CAPACITY)) begin
        cmd = isc_pkg::CMD_INS;
      end
    end
  end

  assign count_ext = {7'd0, count_r};

  // Sequencer with count and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            func_r            <= in_func;
            pend_r            <= '{ival_start: new_start, ival_end: new_end};
            out_overlap_found <= 1'b0;
            out_entry_start   <= '0;
            out_entry_length  <= '0;
            out_status        <= isc_pkg::STATUS_OK;
            out_entry_count   <= count_ext[6:0];
            case (in_func)
              isc_pkg::FUNC_CLEAR: begin
                count_r         <= '0;
                out_entry_count <= '0;
                out_valid       <= 1'b1;
              end
              isc_pkg::FUNC_READ: begin
                if (IW'(in_entry_index) < IW'(count_r)) begin
                  out_entry_start  <= rd_data.ival_start;
                  out_entry_length <= rd_len[32:0];
                end else begin
                  out_status <= isc_pkg::STATUS_RANGE;
                end
                out_valid <= 1'b1;
              end
              default: state_r <= ST_CMP;
            endcase
          end
        end
        ST_CMP: state_r <= ST_EVAL;
        ST_EVAL: begin
          if (func_r == isc_pkg::FUNC_QUERY) begin
            out_overlap_found <= any_ovl;
            out_valid         <= 1'b1;
            state_r           <= ST_IDLE;
          end else if (any_ovl) begin
            // Absorb the lowest overlapping entry and compare again.
            if ($signed(mrg_start) < $signed(pend_r.ival_start)) begin
              pend_r.ival_start <= mrg_start;
            end
            if ($signed(mrg_data.ival_end) > $signed(pend_r.ival_end)) begin
              pend_r.ival_end <= mrg_data.ival_end;
            end
            count_r <= count_r - CW'(1);
            state_r <= ST_CMP;
          end else begin
            if (count_r == CW'(CAPACITY)) begin
              out_status <= isc_pkg::STATUS_FULL;
            end else begin
              count_r         <= count_r + CW'(1);
              out_entry_count <= count_ext[6:0] + 7'd1;
            end
            out_valid <= 1'b1;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY)) else $error("entry count above capacity");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_func == isc_pkg::FUNC_READ || in_func == isc_pkg::FUNC_CLEAR))
    |=> out_valid) else $error("read or clear result missing");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == isc_pkg::STATUS_FULL) |-> count_r == CW'(CAPACITY))
    else $error("table full reported with free cells");
`endif

endmodule
